// ----- hw/rtl/cbce_pkg.sv -----
// ----------------------------------------------------------------------------
// cbce_pkg
// Shared types and constants of the cubic B-spline curve evaluator.
// ----------------------------------------------------------------------------
package cbce_pkg;

   // request codes
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_EVAL = 1'b1;

   // axis code that names no coordinate
   localparam logic [1:0] AXIS_NONE = 2'd3;

   // shared multiplier operand and product widths
   localparam int MUL_A_W = 27;
   localparam int MUL_B_W = 20;
   localparam int MUL_P_W = 47;

   // basis numerator (times 6*2^36) and its split for the coordinate product
   localparam int BASIS_W    = 39;
   localparam int BASIS_LO_W = 19;
   localparam int BASIS_HI_W = BASIS_W - BASIS_LO_W;

   // accumulator of coordinate * basis numerator
   localparam int ACC_W = 56;

   // 4 * 2^36, constant term of the inner basis piece
   localparam logic [39:0] BASIS_FOUR = 40'h40_0000_0000;

   // half of 6*2^36, added before the final floor
   localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(64'h30_0000_0000);

   // offset that keeps the value divided by three non-negative (3 * 2^17)
   localparam logic [18:0] DIV_OFFSET = 19'h6_0000;

   // offset removed again after the divide (2^17)
   localparam logic [18:0] QUO_OFFSET = 19'h2_0000;

   // ceil(2^19 / 3), exact reciprocal for operands below 2^19
   localparam logic [17:0] RECIP_3 = 18'd174763;
   localparam int RECIP_SHIFT = 19;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_POINT,
      ST_CUBE,
      ST_BASIS,
      ST_MLO,
      ST_MHI,
      ST_ACC,
      ST_ROUND,
      ST_DIV,
      ST_FIN
   } cbce_state_type;

endpackage

// ----- hw/rtl/cbce_ram.sv -----
// ----------------------------------------------------------------------------
// cbce_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module cbce_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 24
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/cbce_mul.sv -----
// ----------------------------------------------------------------------------
// cbce_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module cbce_mul
   import cbce_pkg::*;
(
   input  logic                      clock,
   input  logic signed [MUL_A_W-1:0] a,
   input  logic signed [MUL_B_W-1:0] b,
   output logic signed [MUL_P_W-1:0] p
);

   logic signed [MUL_P_W-1:0] prod_ff;

   always_ff @(posedge clock) begin
      prod_ff <= a * b;
   end

   assign p = prod_ff;

endmodule

// ----- hw/rtl/cubic_bspline_curve_eval.sv -----
// ----------------------------------------------------------------------------
// cubic_bspline_curve_eval
// Uniform cubic B-spline curve evaluator over a table of 3-D control points.
// ----------------------------------------------------------------------------
// A load transfer (req_type 0) writes one signed Q8.8 coordinate into the
// point table in the cycle it is taken and produces no response; loads to
// axis 3 or to a point beyond the table are dropped. An evaluate transfer
// (req_type 1) returns one signed Q10.8 value, the sum over the points of
// coordinate * B(t - i), rounded half up. Evaluation walks the addressable
// points one by one: a point outside the basis support takes only the point
// step, a point inside it adds two multiplies for a^3, two for the 16 x 39
// bit coordinate product on one shared 27 x 20 multiplier, basis add and
// accumulate. Rounding and the divide by three (a reciprocal multiply on the
// same multiplier) follow the walk. At most four points are in support at
// once; an evaluate on axis 3 skips the walk and returns zero.
// req_ready is high only between evaluates; loads are taken every cycle while
// no evaluate is in progress. The table resets to zero through one valid flop
// per entry, so no clearing pass is needed. Only points 0..7 can be addressed;
// any further points read zero.
// ----------------------------------------------------------------------------
module cubic_bspline_curve_eval
   import cbce_pkg::*;
#(
   parameter int NUM_POINTS = 8
) (
   input  logic               clock,
   input  logic               reset,

   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_type,
   input  logic [2:0]         req_point_index,
   input  logic [1:0]         req_axis,
   input  logic signed [15:0] req_coord_value,
   input  logic [15:0]        req_eval_time,

   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [17:0] rsp_curve_value
);

   // only eight points are reachable through the 3-bit index
   localparam int WR_POINTS = (NUM_POINTS < 8) ? NUM_POINTS : 8;
   localparam int DEPTH     = WR_POINTS * 3;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int IDX_W     = $clog2(WR_POINTS);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WR_POINTS - 1);

   cbce_state_type state_ff, state_in;

   logic               req_xfer;
   logic               rsp_xfer;

   logic [15:0]        time_ff;
   logic [1:0]         axis_ff;
   logic [IDX_W-1:0]   idx_ff;
   logic [12:0]        m_ff;
   logic               inner_ff;
   logic [24:0]        sq_ff;
   logic signed [15:0] coord_ff;
   logic [BASIS_W-1:0] basis_ff;
   logic [ACC_W-1:0]   acc_ff;
   logic [18:0]        yp_ff;
   logic [17:0]        rsp_value_ff;
   logic               rsp_valid_ff;
   logic [DEPTH-1:0]   vld_ff;
   logic               rd_vld_ff;

   // table port
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr;
   logic               rd_en;
   logic [ADDR_W-1:0]  rd_addr;
   logic [15:0]        rd_data;

   // shared multiplier
   logic signed [MUL_A_W-1:0] mul_a;
   logic signed [MUL_B_W-1:0] mul_b;
   logic signed [MUL_P_W-1:0] prod;
   logic [ACC_W-1:0]          prod_ext;

   // per-point distance |t - i|
   logic [16:0]        diff;
   logic [16:0]        diff_neg;
   logic [15:0]        t_dist;
   logic               near;
   logic               inner;
   logic [12:0]        mag;

   logic [39:0]        inner_basis;
   logic [36:0]        cube;
   logic [ACC_W-1:0]   rnd;
   logic [18:0]        quo;
   logic [18:0]        res;
   logic               fin_go;

   assign req_xfer = req_valid && req_ready;
   assign rsp_xfer = rsp_valid_ff && rsp_ready;

   // ------------------------------------------------------------------------
   // point table
   // ------------------------------------------------------------------------
   assign wr_en = req_xfer && (req_type == REQ_LOAD) && (req_axis != AXIS_NONE) &&
                  ({1'b0, req_point_index} < 4'(WR_POINTS));
   assign wr_addr = ADDR_W'({req_point_index[IDX_W-1:0], 1'b0}) +
                    ADDR_W'(req_point_index[IDX_W-1:0]) + ADDR_W'(req_axis);
   assign rd_addr = ADDR_W'({idx_ff, 1'b0}) + ADDR_W'(idx_ff) + ADDR_W'(axis_ff);

   cbce_ram #(
      .WIDTH (16),
      .DEPTH (DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_coord_value),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   cbce_mul u_mul (
      .clock (clock),
      .a     (mul_a),
      .b     (mul_b),
      .p     (prod)
   );

   assign prod_ext = {{(ACC_W-MUL_P_W){prod[MUL_P_W-1]}}, prod};

   // ------------------------------------------------------------------------
   // datapath terms
   // ------------------------------------------------------------------------
   always_comb begin
      diff     = {1'b0, time_ff} - 17'({idx_ff, 12'd0});
      diff_neg = 17'd0 - diff;
      t_dist   = diff[16] ? diff_neg[15:0] : diff[15:0];
      near     = t_dist < 16'd8192;
      inner    = t_dist < 16'd4096;
      // inner piece uses a, outer piece uses 2 - a
      mag      = inner ? t_dist[12:0] : 13'(16'd8192 - t_dist);
   end

   // 4*2^36 - 6*4096*a^2 + 3*a^3
   assign cube        = prod[36:0];
   assign inner_basis = BASIS_FOUR - ({15'd0, sq_ff} << 14) - ({15'd0, sq_ff} << 13) +
                        ({3'd0, cube} << 1) + {3'd0, cube};

   // floor((sum + 3*2^36) / 2^37) is three times the result, plus rounding
   assign rnd = acc_ff + ROUND_BIAS;
   assign quo = prod[RECIP_SHIFT+18:RECIP_SHIFT];
   assign res = quo - QUO_OFFSET;

   assign fin_go = !rsp_valid_ff || rsp_ready;

   // ------------------------------------------------------------------------
   // sequencer: next state
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer && (req_type == REQ_EVAL)) begin
               state_in = (req_axis == AXIS_NONE) ? ST_ROUND : ST_POINT;
            end
         end
         ST_POINT: begin
            if (near) begin
               state_in = ST_CUBE;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_ROUND;
            end
         end
         ST_CUBE:  state_in = ST_BASIS;
         ST_BASIS: state_in = ST_MLO;
         ST_MLO:   state_in = ST_MHI;
         ST_MHI:   state_in = ST_ACC;
         ST_ACC:   state_in = (idx_ff == LAST_IDX) ? ST_ROUND : ST_POINT;
         ST_ROUND: state_in = ST_DIV;
         ST_DIV:   state_in = ST_FIN;
         ST_FIN: begin
            if (fin_go) begin
               state_in = ST_IDLE;
            end
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // ------------------------------------------------------------------------
   // sequencer: outputs (ready, table read, multiplier operands)
   // ------------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      rd_en     = 1'b0;
      mul_a     = '0;
      mul_b     = '0;
      unique case (state_ff) inside
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_POINT: begin
            rd_en = near;
            mul_a = MUL_A_W'({1'b0, mag});
            mul_b = MUL_B_W'({1'b0, mag});
         end
         ST_CUBE: begin
            mul_a = MUL_A_W'({1'b0, prod[24:0]});
            mul_b = MUL_B_W'({1'b0, m_ff});
         end
         ST_MLO: begin
            mul_a = MUL_A_W'({1'b0, basis_ff[BASIS_LO_W-1:0]});
            mul_b = {{(MUL_B_W-16){coord_ff[15]}}, coord_ff};
         end
         ST_MHI: begin
            mul_a = MUL_A_W'({1'b0, basis_ff[BASIS_W-1:BASIS_LO_W]});
            mul_b = {{(MUL_B_W-16){coord_ff[15]}}, coord_ff};
         end
         // operands held in FIN so the quotient stays put while the output waits
         ST_DIV, ST_FIN: begin
            mul_a = MUL_A_W'({1'b0, yp_ff});
            mul_b = MUL_B_W'({1'b0, RECIP_3});
         end
         ST_BASIS, ST_ACC, ST_ROUND: begin
         end
         default: begin
         end
      endcase
   end

   // ------------------------------------------------------------------------
   // control registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff <= state_in;
         if (wr_en) begin
            vld_ff[wr_addr] <= 1'b1;
         end
         if (state_ff == ST_FIN && fin_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_xfer) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_IDLE) begin
            idx_ff <= '0;
         end else if ((state_ff == ST_POINT && !near && idx_ff != LAST_IDX) ||
                      (state_ff == ST_ACC && idx_ff != LAST_IDX)) begin
            idx_ff <= idx_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // datapath registers
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && req_xfer) begin
         time_ff <= req_eval_time;
         axis_ff <= req_axis;
         acc_ff  <= '0;
      end
      if (state_ff == ST_POINT) begin
         m_ff      <= mag;
         inner_ff  <= inner;
         rd_vld_ff <= vld_ff[rd_addr];
      end
      if (state_ff == ST_CUBE) begin
         sq_ff    <= prod[24:0];
         // never-written entries read as zero
         coord_ff <= rd_vld_ff ? signed'(rd_data) : 16'sd0;
      end
      if (state_ff == ST_BASIS) begin
         basis_ff <= inner_ff ? inner_basis[BASIS_W-1:0] : BASIS_W'(cube);
      end
      if (state_ff == ST_MHI) begin
         acc_ff <= acc_ff + prod_ext;
      end
      if (state_ff == ST_ACC) begin
         acc_ff <= acc_ff + (prod_ext << BASIS_LO_W);
      end
      if (state_ff == ST_ROUND) begin
         yp_ff <= rnd[ACC_W-1:37] + DIV_OFFSET;
      end
      if (state_ff == ST_FIN && fin_go) begin
         rsp_value_ff <= res[17:0];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_curve_value = signed'(rsp_value_ff);

endmodule
